@@ hw/rtl/vmc_pkg.sv @@
// Shared types, constants and lookup functions for the vending credit and change controller.
package vmc_pkg;

  localparam int NUM_ITEMS_DEF       = 5;
  localparam int STOCK_BITS_DEF      = 8;
  localparam int COIN_COUNT_BITS_DEF = 16;

  localparam int NUM_DENOMS     = 5;
  localparam int NUM_PRICE_REGS = 5;
  localparam int CREDIT_W       = 13;
  localparam int NOTE_W         = 4;
  localparam int DENOM_W        = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int QUOT_W         = 10;
  localparam int PAY_W          = 9;
  localparam int RECIP_W        = 21;
  localparam int RECIP_SHIFT    = 24;
  localparam int STOCK_OUT_W    = 8;

  localparam int COIN_RESET         = 5;
  localparam int STOCK_RESET        = 3;
  localparam int CREDIT_LIMIT_RESET = 5000;
  localparam int NOTE_LIMIT_RESET   = 3;
  localparam logic [NOTE_W-1:0] NOTE_MAX = '1;

  // denomination codes, shared by coin_code and the refund walk
  localparam logic [DENOM_W-1:0] DEN_10   = 3'd0;
  localparam logic [DENOM_W-1:0] DEN_50   = 3'd1;
  localparam logic [DENOM_W-1:0] DEN_100  = 3'd2;
  localparam logic [DENOM_W-1:0] DEN_500  = 3'd3;
  localparam logic [DENOM_W-1:0] DEN_1000 = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CREDIT_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LIMIT   = 3'd6;

  typedef enum logic [1:0] {
    MODE_COIN    = 2'd0,
    MODE_SELECT  = 2'd1,
    MODE_REFUND  = 2'd2,
    MODE_RESTOCK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_INVALID      = 3'd1,
    STAT_OVER_CREDIT  = 3'd2,
    STAT_NOTE_LIMIT   = 3'd3,
    STAT_SHORT_CREDIT = 3'd4,
    STAT_SOLD_OUT     = 3'd5,
    STAT_CHANGE_SHORT = 3'd6,
    STAT_BAD_COUNT    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REF_DIV,
    S_REF_PAY,
    S_REF_END,
    S_OUT
  } state_e;

  typedef struct packed {
    mode_e      mode;
    logic [2:0] coin_code;
    logic [2:0] item_index;
    logic [7:0] restock_count;
  } vmc_req_t;

  typedef struct packed {
    status_e             status;
    logic [CREDIT_W-1:0] credit;
    logic                vended;
    logic [7:0]          stock_left;
    logic [2:0]          paid_1000;
    logic [3:0]          paid_500;
    logic [5:0]          paid_100;
    logic [6:0]          paid_50;
    logic [8:0]          paid_10;
  } vmc_rsp_t;

  typedef struct packed {
    logic               start;
    logic               exec;
    logic               ref_div;
    logic               ref_pay;
    logic               ref_end;
    logic               load_out;
    logic [DENOM_W-1:0] denom;
  } vmc_cmd_t;

  function automatic logic [QUOT_W-1:0] denom_value(logic [DENOM_W-1:0] idx);
    logic [QUOT_W-1:0] v;
    case (idx)
      DEN_10:   v = 10'd10;
      DEN_50:   v = 10'd50;
      DEN_100:  v = 10'd100;
      DEN_500:  v = 10'd500;
      DEN_1000: v = 10'd1000;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // ceil(2^24 / value): exact floor division for any 13-bit credit
  function automatic logic [RECIP_W-1:0] denom_recip(logic [DENOM_W-1:0] idx);
    logic [RECIP_W-1:0] r;
    case (idx)
      DEN_10:   r = 21'd1677722;
      DEN_50:   r = 21'd335545;
      DEN_100:  r = 21'd167773;
      DEN_500:  r = 21'd33555;
      DEN_1000: r = 21'd16778;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // most pieces a refund can report per denomination
  function automatic logic [PAY_W-1:0] paid_cap(logic [DENOM_W-1:0] idx);
    logic [PAY_W-1:0] c;
    case (idx)
      DEN_10:   c = 9'd511;
      DEN_50:   c = 9'd127;
      DEN_100:  c = 9'd63;
      DEN_500:  c = 9'd15;
      DEN_1000: c = 9'd7;
      default:  c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CREDIT_W-1:0] price_reset(int idx);
    logic [CREDIT_W-1:0] p;
    case (idx)
      0:       p = 13'd450;
      1:       p = 13'd500;
      2:       p = 13'd550;
      3:       p = 13'd700;
      default: p = 13'd750;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/vending_credit_and_change_controller_top.sv @@
// Top level of the vending credit and change controller.
//
//   channel  direction  signals                              moves
//   in       sink       in_valid_i / in_stall_o / in_data_i  one request (vmc_req_t)
//   out      source     out_valid_o / out_stall_i / out_data_o  one result (vmc_rsp_t)
//   cfg      sink       cfg_we_i / cfg_index_i / cfg_wdata_i   register write, no wait
//
// One request at a time. For coin, select and restock the request is executed in
// the execute state and the result is loaded into the output register; for refund
// each of the five denominations takes a reciprocal multiply, then a clamp and pay
// out, then status is settled and the output register is loaded. out_valid_o rises
// with that load, which waits while out_stall_i holds a pending result. The next request is taken after it.
// in_stall_o is low only while the sequencer is idle; a finished result waits in
// the output register while the next request is taken.
// Reset is asynchronous; counts, stock and configuration registers return to their defaults.
module vending_credit_and_change_controller_top import vmc_pkg::*; #(
  parameter int NUM_ITEMS       = NUM_ITEMS_DEF,
  parameter int STOCK_BITS      = STOCK_BITS_DEF,
  parameter int COIN_COUNT_BITS = COIN_COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  vmc_req_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output vmc_rsp_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CREDIT_W-1:0]  cfg_wdata_i
);

  vmc_cmd_t cmd;

  vmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  vmc_dp #(
    .NUM_ITEMS       (NUM_ITEMS),
    .STOCK_BITS      (STOCK_BITS),
    .COIN_COUNT_BITS (COIN_COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_data_o)
  );

endmodule

@@ hw/rtl/vmc_ctrl.sv @@
// Controller state machine: request sequencing, refund walk and output handshake.
module vmc_ctrl import vmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  mode_e    in_mode_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output vmc_cmd_t cmd_o
);

  state_e             state_q, state_d;
  logic [DENOM_W-1:0] denom_q, denom_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    denom_d = denom_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          denom_d = DEN_1000;
          state_d = (in_mode_i == MODE_REFUND) ? S_REF_DIV : S_EXEC;
        end
      end
      S_EXEC:    state_d = S_OUT;
      S_REF_DIV: state_d = S_REF_PAY;
      S_REF_PAY: begin
        denom_d = denom_q - 3'd1;
        state_d = (denom_q == DEN_10) ? S_REF_END : S_REF_DIV;
      end
      S_REF_END: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.denom = denom_q;
    case (state_q)
      S_IDLE:    cmd_o.start    = in_valid_i;
      S_EXEC:    cmd_o.exec     = 1'b1;
      S_REF_DIV: cmd_o.ref_div  = 1'b1;
      S_REF_PAY: cmd_o.ref_pay  = 1'b1;
      S_REF_END: cmd_o.ref_end  = 1'b1;
      S_OUT:     cmd_o.load_out = out_free;
      default:   cmd_o.start    = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == S_OUT) && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      denom_q     <= DEN_1000;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      denom_q     <= denom_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/vmc_dp.sv @@
// Datapath: configuration, credit, note count, coin store, item stock and result registers.
module vmc_dp import vmc_pkg::*; #(
  parameter int NUM_ITEMS       = NUM_ITEMS_DEF,
  parameter int STOCK_BITS      = STOCK_BITS_DEF,
  parameter int COIN_COUNT_BITS = COIN_COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vmc_cmd_t             cmd_i,
  input  vmc_req_t             req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CREDIT_W-1:0]  cfg_wdata_i,
  output vmc_rsp_t             rsp_o
);

  localparam int SumW = ((STOCK_BITS > STOCK_OUT_W) ? STOCK_BITS : STOCK_OUT_W) + 1;
  localparam int CntW = (COIN_COUNT_BITS > QUOT_W) ? COIN_COUNT_BITS : QUOT_W;
  localparam logic [3:0] NumItemsL = 4'(NUM_ITEMS);

  logic [CREDIT_W-1:0]        price_q [NUM_PRICE_REGS];
  logic [CREDIT_W-1:0]        climit_q;
  logic [NOTE_W-1:0]          nlimit_q;
  logic [CREDIT_W-1:0]        credit_q, credit_d;
  logic [NOTE_W-1:0]          notes_q, notes_d;
  logic [COIN_COUNT_BITS-1:0] coins_q [NUM_DENOMS];
  logic [STOCK_BITS-1:0]      stock_q [NUM_ITEMS];
  logic [QUOT_W-1:0]          quot_q;
  vmc_req_t                   req_q;
  vmc_rsp_t                   res_q;
  vmc_rsp_t                   out_q;
  vmc_rsp_t                   out_nx;

  logic [CREDIT_W-1:0]        price_rd;
  logic [STOCK_BITS-1:0]      stock_rd;
  logic [COIN_COUNT_BITS-1:0] coin_rd;
  logic [DENOM_W-1:0]         sel_idx;

  logic                       item_ok, coin_ok, is_note, note_refuse, over, coin_take;
  logic [NOTE_W-1:0]          notes_inc;
  logic [CREDIT_W:0]          credit_add;
  logic [SumW-1:0]            restock_sum, stock_ext;
  logic [STOCK_BITS-1:0]      stock_nx;
  logic [CREDIT_W-1:0]        credit_nx;
  logic [NOTE_W-1:0]          notes_nx;
  status_e                    status_nx;
  logic                       vended_nx;
  logic [STOCK_OUT_W-1:0]     stock_left_nx;

  logic [RECIP_SHIFT+QUOT_W-1:0] prod;
  logic [CntW-1:0]            quot_ext, coin_ext, lim;
  logic [PAY_W-1:0]           pay_n;
  logic [PAY_W+QUOT_W-1:0]    pay_amt;
  logic [CREDIT_W-1:0]        credit_pay;

  always_comb begin
    price_rd = '0;
    for (int i = 0; i < NUM_PRICE_REGS; i++) begin
      if (req_q.item_index == 3'(i)) begin
        price_rd = price_q[i];
      end
    end
    stock_rd = '0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (req_q.item_index == 3'(i)) begin
        stock_rd = stock_q[i];
      end
    end
    sel_idx = cmd_i.ref_pay ? cmd_i.denom : req_q.coin_code;
    coin_rd = '0;
    for (int i = 0; i < NUM_DENOMS; i++) begin
      if (sel_idx == 3'(i)) begin
        coin_rd = coins_q[i];
      end
    end
  end

  // combinational handling of coin, select and restock, applied on exec
  always_comb begin
    item_ok     = ({1'b0, req_q.item_index} < NumItemsL) &&
                  (req_q.item_index < 3'(NUM_PRICE_REGS));
    coin_ok     = (req_q.coin_code < 3'(NUM_DENOMS));
    is_note     = (req_q.coin_code == DEN_1000);
    notes_inc   = (notes_q != NOTE_MAX) ? notes_q + 4'd1 : notes_q;
    note_refuse = is_note && (notes_inc > nlimit_q);
    credit_add  = {1'b0, credit_q} + 14'(denom_value(req_q.coin_code));
    over        = credit_add > {1'b0, climit_q};
    coin_take   = coin_ok && !note_refuse && !over;
    restock_sum = SumW'(stock_rd) + SumW'(req_q.restock_count);

    status_nx     = STAT_OK;
    vended_nx     = 1'b0;
    credit_nx     = credit_q;
    notes_nx      = notes_q;
    stock_nx      = stock_rd;
    stock_left_nx = '0;

    case (req_q.mode)
      MODE_COIN: begin
        if (!coin_ok) begin
          status_nx = STAT_INVALID;
        end else begin
          if (is_note) begin
            notes_nx = notes_inc;
          end
          if (note_refuse) begin
            status_nx = STAT_NOTE_LIMIT;
          end else if (over) begin
            status_nx = STAT_OVER_CREDIT;
          end else begin
            credit_nx = credit_add[CREDIT_W-1:0];
          end
        end
      end
      MODE_SELECT: begin
        if (!item_ok) begin
          status_nx = STAT_INVALID;
        end else if ((stock_rd != '0) && (credit_q >= price_rd)) begin
          stock_nx  = stock_rd - STOCK_BITS'(1);
          credit_nx = credit_q - price_rd;
          vended_nx = 1'b1;
        end else if (stock_rd == '0) begin
          status_nx = STAT_SOLD_OUT;
        end else begin
          status_nx = STAT_SHORT_CREDIT;
        end
      end
      MODE_RESTOCK: begin
        if (!item_ok) begin
          status_nx = STAT_INVALID;
        end else if (req_q.restock_count == '0) begin
          status_nx = STAT_BAD_COUNT;
        end else if (|restock_sum[SumW-1:STOCK_BITS]) begin
          stock_nx = '1;
        end else begin
          stock_nx = restock_sum[STOCK_BITS-1:0];
        end
      end
      default: status_nx = STAT_OK;
    endcase

    stock_ext = SumW'(stock_nx);
    if (item_ok && ((req_q.mode == MODE_SELECT) || (req_q.mode == MODE_RESTOCK))) begin
      stock_left_nx = stock_ext[STOCK_OUT_W-1:0];
    end
  end

  // refund: quotient by reciprocal, then clamp to store and field cap
  always_comb begin
    prod       = (RECIP_SHIFT + QUOT_W)'(credit_q) *
                 (RECIP_SHIFT + QUOT_W)'(denom_recip(cmd_i.denom));
    quot_ext   = CntW'(quot_q);
    coin_ext   = CntW'(coin_rd);
    lim        = (quot_ext < coin_ext) ? quot_ext : coin_ext;
    pay_n      = (lim > CntW'(paid_cap(cmd_i.denom))) ? paid_cap(cmd_i.denom)
                                                      : lim[PAY_W-1:0];
    pay_amt    = (PAY_W + QUOT_W)'(pay_n) * (PAY_W + QUOT_W)'(denom_value(cmd_i.denom));
    credit_pay = credit_q - pay_amt[CREDIT_W-1:0];
  end

  always_comb begin
    out_nx        = res_q;
    out_nx.credit = credit_q;
  end

  always_comb begin
    credit_d = credit_q;
    notes_d  = notes_q;
    if (cmd_i.exec) begin
      credit_d = credit_nx;
      notes_d  = notes_nx;
    end else if (cmd_i.ref_pay) begin
      credit_d = credit_pay;
    end else if (cmd_i.ref_end) begin
      notes_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PRICE_REGS; i++) begin
        price_q[i] <= price_reset(i);
      end
      climit_q <= CREDIT_W'(CREDIT_LIMIT_RESET);
      nlimit_q <= NOTE_W'(NOTE_LIMIT_RESET);
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_PRICE_REGS; i++) begin
        if (cfg_index_i == 3'(i)) begin
          price_q[i] <= cfg_wdata_i;
        end
      end
      if (cfg_index_i == REG_CREDIT_LIMIT) begin
        climit_q <= cfg_wdata_i;
      end
      if (cfg_index_i == REG_NOTE_LIMIT) begin
        nlimit_q <= cfg_wdata_i[NOTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
      notes_q  <= '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
        coins_q[i] <= COIN_COUNT_BITS'(COIN_RESET);
      end
      for (int i = 0; i < NUM_ITEMS; i++) begin
        stock_q[i] <= STOCK_BITS'(STOCK_RESET);
      end
    end else begin
      credit_q <= credit_d;
      notes_q  <= notes_d;
      for (int i = 0; i < NUM_DENOMS; i++) begin
        if (sel_idx == 3'(i)) begin
          if (cmd_i.exec && (req_q.mode == MODE_COIN) && coin_take && (coin_rd != '1)) begin
            coins_q[i] <= coin_rd + COIN_COUNT_BITS'(1);
          end else if (cmd_i.ref_pay) begin
            coins_q[i] <= coin_rd - COIN_COUNT_BITS'(pay_n);
          end
        end
      end
      for (int i = 0; i < NUM_ITEMS; i++) begin
        if (cmd_i.exec && item_ok && (req_q.item_index == 3'(i))) begin
          stock_q[i] <= stock_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q <= req_i;
      res_q <= '0;
    end
    if (cmd_i.exec) begin
      res_q.status     <= status_nx;
      res_q.vended     <= vended_nx;
      res_q.stock_left <= stock_left_nx;
    end
    if (cmd_i.ref_div) begin
      quot_q <= prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    end
    if (cmd_i.ref_pay) begin
      case (cmd_i.denom)
        DEN_1000: res_q.paid_1000 <= pay_n[2:0];
        DEN_500:  res_q.paid_500  <= pay_n[3:0];
        DEN_100:  res_q.paid_100  <= pay_n[5:0];
        DEN_50:   res_q.paid_50   <= pay_n[6:0];
        DEN_10:   res_q.paid_10   <= pay_n;
        default:  res_q.paid_10   <= res_q.paid_10;
      endcase
    end
    if (cmd_i.ref_end) begin
      res_q.status <= (credit_q != '0) ? STAT_CHANGE_SHORT : STAT_OK;
    end
    if (cmd_i.load_out) begin
      out_q <= out_nx;
    end
  end

  assign rsp_o = out_q;

endmodule

@@ dv/vending_credit_and_change_controller_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the vending credit and change controller: directed and random requests checked against a model.
module vending_credit_and_change_controller_top_tb;
  import vmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned BURST_HOLD   = 300;
  localparam int unsigned COIN_FULL    = (1 << COIN_COUNT_BITS_DEF) - 1;
  localparam int unsigned STOCK_FULL   = (1 << STOCK_BITS_DEF) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_PRICE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [DENOM_W-1:0]   COIN_BAD_LO = 3'd5;
  localparam logic [DENOM_W-1:0]   COIN_BAD_HI = 3'd7;

  class vend_scoreboard;
    int unsigned price [NUM_PRICE_REGS];
    int unsigned credit_cap;
    int unsigned note_cap;
    int unsigned credit;
    int unsigned notes;
    int unsigned coin_store [NUM_DENOMS];
    int unsigned stock [NUM_ITEMS_DEF];
    int unsigned worth [NUM_DENOMS];
    int unsigned pay_cap [NUM_DENOMS];
    vmc_rsp_t    pending_results [$];
    int unsigned errors;

    function new();
      worth      = '{10, 50, 100, 500, 1000};
      pay_cap    = '{511, 127, 63, 15, 7};
      price      = '{450, 500, 550, 700, 750};
      credit_cap = CREDIT_LIMIT_RESET;
      note_cap   = NOTE_LIMIT_RESET;
      credit     = 0;
      notes      = 0;
      errors     = 0;
      foreach (coin_store[i]) coin_store[i] = COIN_RESET;
      foreach (stock[i]) stock[i] = STOCK_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CREDIT_W-1:0] val);
      if (idx < NUM_PRICE_REGS) begin
        price[idx] = val;
      end else if (idx == REG_CREDIT_LIMIT) begin
        credit_cap = val;
      end else if (idx == REG_NOTE_LIMIT) begin
        note_cap = val[NOTE_W-1:0];
      end
    endfunction

    function void note_request(vmc_req_t r);
      vmc_rsp_t    o;
      int unsigned v;
      int unsigned n;
      int unsigned it;
      bit          refuse;
      o = '0;
      o.status = STAT_OK;
      it = r.item_index;
      case (r.mode)
        MODE_COIN: begin
          if (r.coin_code > DEN_1000) begin
            o.status = STAT_INVALID;
          end else begin
            refuse = 1'b0;
            v = worth[r.coin_code];
            if (r.coin_code == DEN_1000) begin
              if (notes < 15) notes++;
              if (notes > note_cap) begin
                o.status = STAT_NOTE_LIMIT;
                refuse = 1'b1;
              end
            end
            if (!refuse && credit + v > credit_cap) begin
              o.status = STAT_OVER_CREDIT;
              refuse = 1'b1;
            end
            if (!refuse) begin
              credit += v;
              if (coin_store[r.coin_code] < COIN_FULL) coin_store[r.coin_code]++;
            end
          end
        end
        MODE_SELECT: begin
          if (it >= NUM_ITEMS_DEF || it >= NUM_PRICE_REGS) begin
            o.status = STAT_INVALID;
          end else begin
            if (credit >= price[it] && stock[it] != 0) begin
              stock[it]--;
              credit -= price[it];
              o.vended = 1'b1;
            end else if (stock[it] == 0) begin
              o.status = STAT_SOLD_OUT;
            end else begin
              o.status = STAT_SHORT_CREDIT;
            end
            o.stock_left = 8'(stock[it]);
          end
        end
        MODE_REFUND: begin
          for (int d = NUM_DENOMS - 1; d >= 0; d--) begin
            n = credit / worth[d];
            if (n > coin_store[d]) n = coin_store[d];
            if (n > pay_cap[d]) n = pay_cap[d];
            credit -= n * worth[d];
            coin_store[d] -= n;
            case (d)
              DEN_1000: o.paid_1000 = 3'(n);
              DEN_500:  o.paid_500  = 4'(n);
              DEN_100:  o.paid_100  = 6'(n);
              DEN_50:   o.paid_50   = 7'(n);
              default:  o.paid_10   = 9'(n);
            endcase
          end
          if (credit != 0) o.status = STAT_CHANGE_SHORT;
          notes = 0;
        end
        default: begin
          if (it >= NUM_ITEMS_DEF || it >= NUM_PRICE_REGS) begin
            o.status = STAT_INVALID;
          end else begin
            if (r.restock_count == 0) begin
              o.status = STAT_BAD_COUNT;
            end else begin
              v = stock[it] + r.restock_count;
              stock[it] = (v > STOCK_FULL) ? STOCK_FULL : v;
            end
            o.stock_left = 8'(stock[it]);
          end
        end
      endcase
      o.credit = CREDIT_W'(credit);
      pending_results.push_back(o);
    endfunction

    function void show(string field, int unsigned want, int unsigned got);
      if (want != got) $display("%0t:   %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_result(vmc_rsp_t got);
      vmc_rsp_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch, expected %h got %h", $time, want, got);
        show("status", int'(want.status), int'(got.status));
        show("credit", want.credit, got.credit);
        show("vended", want.vended, got.vended);
        show("stock_left", want.stock_left, got.stock_left);
        show("paid_1000", want.paid_1000, got.paid_1000);
        show("paid_500", want.paid_500, got.paid_500);
        show("paid_100", want.paid_100, got.paid_100);
        show("paid_50", want.paid_50, got.paid_50);
        show("paid_10", want.paid_10, got.paid_10);
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  vmc_req_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  vmc_rsp_t             out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CREDIT_W-1:0]  cfg_wdata_i = '0;

  vend_scoreboard sb;
  bit             gaps_on         = 1'b1;
  bit             big_coins       = 1'b0;
  bit             stall_burst_req = 1'b0;
  int unsigned    cycle_count     = 0;

  vending_credit_and_change_controller_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic vmc_req_t make_req(mode_e m, logic [2:0] coin, logic [2:0] item,
                                        logic [7:0] cnt);
    vmc_req_t r;
    r.mode          = m;
    r.coin_code     = coin;
    r.item_index    = item;
    r.restock_count = cnt;
    return r;
  endfunction

  function automatic vmc_req_t random_request();
    vmc_req_t    r;
    int unsigned pick;
    r.mode          = MODE_REFUND;
    r.coin_code     = 3'($urandom_range(7));
    r.item_index    = 3'($urandom_range(7));
    r.restock_count = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.mode = MODE_COIN;
      if ($urandom_range(99) < 8) begin
        r.coin_code = 3'($urandom_range(COIN_BAD_HI, COIN_BAD_LO));
      end else if (big_coins) begin
        r.coin_code = $urandom_range(1) ? DEN_1000 : DEN_500;
      end else begin
        r.coin_code = 3'($urandom_range(DEN_1000));
      end
    end else if (pick < 72) begin
      r.mode = MODE_SELECT;
      if ($urandom_range(99) >= 8) r.item_index = 3'($urandom_range(NUM_ITEMS_DEF - 1));
    end else if (pick < 84) begin
      r.mode = MODE_REFUND;
    end else begin
      r.mode = MODE_RESTOCK;
      if ($urandom_range(99) >= 8) r.item_index = 3'($urandom_range(NUM_ITEMS_DEF - 1));
      pick = $urandom_range(99);
      if (pick < 6) begin
        r.restock_count = '0;
      end else if (pick < 97) begin
        r.restock_count = 8'($urandom_range(6, 1));
      end
    end
    return r;
  endfunction

  // valid stays high after a request is taken; the next call either replaces the
  // payload in the same step or drops valid for a gap
  task automatic send_request(input vmc_req_t r);
    while (gaps_on && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_request(random_request());
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CREDIT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic randomize_regs();
    for (int i = 0; i < NUM_PRICE_REGS; i++) begin
      write_reg(REG_PRICE0 + CFG_IDX_W'(i), CREDIT_W'($urandom_range(5000)));
    end
    write_reg(REG_CREDIT_LIMIT, CREDIT_W'($urandom_range(5000)));
    write_reg(REG_NOTE_LIMIT, CREDIT_W'($urandom_range(15)));
  endtask

  // result side
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (stall_burst_req) begin
        hold_left       = BURST_HOLD;
        stall_burst_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= gaps_on && ($urandom_range(99) < 7);
      end
    end
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_req(MODE_REFUND, DEN_10, 3'd0, 8'd0));
    send_request(make_req(MODE_COIN, COIN_BAD_LO, 3'd0, 8'd0));
    send_request(make_req(MODE_COIN, COIN_BAD_HI, 3'd0, 8'd0));
    send_request(make_req(MODE_COIN, DEN_10, 3'd0, 8'd0));
    send_request(make_req(MODE_COIN, DEN_50, 3'd0, 8'd0));
    send_request(make_req(MODE_COIN, DEN_100, 3'd0, 8'd0));
    send_request(make_req(MODE_COIN, DEN_500, 3'd0, 8'd0));
    repeat (4) send_request(make_req(MODE_COIN, DEN_1000, 3'd0, 8'd0));
    repeat (3) send_request(make_req(MODE_COIN, DEN_500, 3'd0, 8'd0));
    send_request(make_req(MODE_SELECT, DEN_10, 3'd7, 8'd0));
    send_request(make_req(MODE_SELECT, DEN_10, 3'd0, 8'd0));
    repeat (4) send_request(make_req(MODE_SELECT, DEN_10, 3'd1, 8'd0));
    send_request(make_req(MODE_RESTOCK, DEN_10, 3'd4, 8'd255));
    send_request(make_req(MODE_RESTOCK, DEN_10, 3'd2, 8'd0));
    send_request(make_req(MODE_RESTOCK, DEN_10, 3'd6, 8'd5));
    send_request(make_req(MODE_REFUND, DEN_10, 3'd0, 8'd0));
    send_request(make_req(MODE_SELECT, DEN_10, 3'd2, 8'd0));

    // reset settings, with one long hold on the result side
    run_random(100);
    stall_burst_req = 1'b1;
    run_random(400);
    finish_phase();

    // everything free, no credit accepted, no notes
    for (int i = 0; i < NUM_PRICE_REGS; i++) write_reg(REG_PRICE0 + CFG_IDX_W'(i), '0);
    write_reg(REG_CREDIT_LIMIT, '0);
    write_reg(REG_NOTE_LIMIT, '0);
    write_reg(REG_UNUSED, '1);
    run_random(150);
    finish_phase();

    // top prices and odd amounts that leave change the store cannot pay
    gaps_on = 1'b0;
    write_reg(REG_PRICE0, 13'd5000);
    write_reg(REG_PRICE0 + 3'd1, 13'd4095);
    write_reg(REG_PRICE0 + 3'd2, 13'd1);
    write_reg(REG_PRICE0 + 3'd3, 13'd10);
    write_reg(REG_PRICE0 + 3'd4, 13'd4999);
    write_reg(REG_CREDIT_LIMIT, 13'd5000);
    write_reg(REG_NOTE_LIMIT, 13'd15);
    run_random(400);
    finish_phase();
    gaps_on = 1'b1;

    for (int round = 0; round < 3; round++) begin
      big_coins = (round != 1);
      randomize_regs();
      run_random(300);
      finish_phase();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
